>>> rtl/qwos_pkg.sv
`timescale 1ns / 1ps

package qwos_pkg;

    localparam int MAX_LEN_DEF = 256;

    // fixed field widths
    localparam int OPC_W  = 2;
    localparam int BYTE_W = 8;
    localparam int OUT_W  = 9;
    localparam int MIN_W  = 9;
    localparam int MPEN_W = 6;
    localparam int HITS_W = 4;
    localparam int CFGA_W = 3;
    localparam int CFGD_W = 9;

    localparam logic [HITS_W-1:0] HIT_CAP = 4'd8;
    localparam logic [1:0]        HIGH_PEN = 2'd3;
    localparam logic [1:0]        LOW_PEN  = 2'd1;

    localparam logic [OPC_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPC_W-1:0] OP_START       = 2'd2;

    localparam logic [1:0] MODE_FORWARD   = 2'd0;
    localparam logic [1:0] MODE_REVERSE   = 2'd1;
    localparam logic [1:0] MODE_CONTAINED = 2'd2;

    localparam logic [CFGA_W-1:0] REG_SEARCH_MODE = 3'd0;
    localparam logic [CFGA_W-1:0] REG_MAX_PENALTY = 3'd1;
    localparam logic [CFGA_W-1:0] REG_MIN_OVERLAP = 3'd2;
    localparam logic [CFGA_W-1:0] REG_MAX_HITS    = 3'd3;
    localparam logic [CFGA_W-1:0] REG_USE_QUAL2   = 3'd4;
    localparam logic [CFGA_W-1:0] REG_QUAL_THR    = 3'd5;

    localparam logic [1:0]        RST_SEARCH_MODE = MODE_FORWARD;
    localparam logic [MPEN_W-1:0] RST_MAX_PENALTY = 6'd2;
    localparam logic [MIN_W-1:0]  RST_MIN_OVERLAP = 9'd10;
    localparam logic [HITS_W-1:0] RST_MAX_HITS    = 4'd4;
    localparam logic              RST_USE_QUAL2   = 1'b1;
    localparam logic [BYTE_W-1:0] RST_QUAL_THR    = 8'd53;

endpackage

>>> rtl/qwos_ram.sv
`timescale 1ns / 1ps

module qwos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/quality_weighted_overlap_search.sv
`timescale 1ns / 1ps

// Quality-weighted ungapped overlap search. Load transfers (one base and one
// quality byte each) are taken one per cycle while idle and append to
// sequence one or sequence two; a load into a full store is dropped. A start
// transfer runs the search in the mode held in the configuration registers
// and holds s_tready low until the final result has been placed in the
// output register. Search time is set by one shared compare/penalty unit
// behind a registered store read: each candidate passes a setup state, an
// address and a compare state per scanned position and a decision state,
// and a flush state ends the search. Results leave on the master side in
// order, m_tlast marking the final one; a search without hits gives one
// result with hit_found low. Store contents are not cleared at reset, only the
// fill counts, which clear after each search. The user writes configuration
// through the cfg channel only while idle; the block does not enforce this.
module quality_weighted_overlap_search
    import qwos_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // base_byte, quality_byte, zero fill
    input  logic [OPC_W-1:0]  s_tuser,   // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // hit_start, hit_length, zero fill
    output logic [0:0]        m_tuser,   // hit_found
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGA_W-1:0] cfg_addr,
    input  logic [CFGD_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int LW  = (CW > MIN_W) ? CW : MIN_W;
    localparam int IW  = LW + 1;
    localparam int PW  = $clog2(3 * MAX_LEN + 1);
    localparam int PLW = PW + LW;
    localparam int KW  = CW + MPEN_W;
    localparam int RW  = 2 * BYTE_W;

    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAND  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // configuration
    logic [1:0]        mode_reg;
    logic [MPEN_W-1:0] max_pen_reg;
    logic [MIN_W-1:0]  min_ovl_reg;
    logic [HITS_W-1:0] max_hits_reg;
    logic              use_q2_reg;
    logic [BYTE_W-1:0] q_thr_reg;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     first_cnt_reg, first_cnt_next;
    logic [CW-1:0]     second_cnt_reg, second_cnt_next;
    logic [IW-1:0]     cand_reg, cand_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     span_reg, span_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [PW-1:0]     pen_reg, pen_next;
    logic [PLW-1:0]    pl_reg, pl_next;
    logic [KW-1:0]     kmp_reg, kmp_next;
    logic [LW-1:0]     lim_reg, lim_next;
    logic [LW+1:0]     lim3_reg, lim3_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [AW-1:0]     b_reg, b_next;
    logic [HITS_W-1:0] hits_reg, hits_next;
    logic [HITS_W-1:0] cap_reg, cap_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [OUT_W-1:0]  pend_start_reg, pend_start_next;
    logic [OUT_W-1:0]  pend_len_reg, pend_len_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [OUT_W-1:0]  out_start_reg, out_start_next;
    logic [OUT_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    logic              we_first, we_second;
    logic [RW-1:0]     wdata;
    logic [RW-1:0]     rd_first, rd_second;

    logic [OPC_W-1:0]  in_op;
    logic [BYTE_W-1:0] in_base, in_qual;
    logic              in_xfer, out_free;
    logic              fwd_rev;
    logic [IW-1:0]     l1_x, l2_x;
    logic              cand_ok;
    logic [CW-1:0]     span_c;
    logic              mismatch, high_q, stop;
    logic [PW-1:0]     pen_upd;
    logic [PLW-1:0]    pl_upd;
    logic              accept;
    logic [IW-1:0]     start_x;

    assign in_op    = s_tuser;
    assign in_base  = s_tdata[7:0];
    assign in_qual  = s_tdata[15:8];
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign wdata    = {in_qual, in_base};

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_found_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{(24 - 2 * OUT_W){1'b0}}, out_len_reg, out_start_reg};

    assign fwd_rev = (mode_reg == MODE_FORWARD) || (mode_reg == MODE_REVERSE);
    assign l1_x    = IW'(first_cnt_reg);
    assign l2_x    = IW'(second_cnt_reg);

    always_comb begin
        if (fwd_rev) begin
            cand_ok = (cand_reg <= l1_x) && (hits_reg < cap_reg);
            span_c  = (cand_reg < l2_x) ? cand_reg[CW-1:0] : second_cnt_reg;
        end else if (mode_reg == MODE_CONTAINED) begin
            cand_ok = ((l1_x + cand_reg) < l2_x) && (hits_reg < cap_reg);
            span_c  = first_cnt_reg;
        end else begin
            cand_ok = 1'b0;
            span_c  = first_cnt_reg;
        end
    end

    // shared compare and penalty unit
    always_comb begin
        mismatch = (rd_first[7:0] != rd_second[7:0]);
        high_q   = (rd_first[15:8] >= q_thr_reg) &&
                   (!use_q2_reg || (rd_second[15:8] >= q_thr_reg));
        pen_upd  = pen_reg + PW'(high_q ? HIGH_PEN : LOW_PEN);
        pl_upd   = pl_reg + (high_q ? PLW'(lim3_reg) : PLW'(lim_reg));
        if (LW'(k_reg) <= lim_reg) begin
            stop = mismatch && (pen_upd > PW'(max_pen_reg));
        end else begin
            stop = mismatch && (pl_upd > PLW'(kmp_reg));
        end
    end

    always_comb begin
        if (fwd_rev) begin
            accept  = (LW'(len_reg) >= LW'(min_ovl_reg)) &&
                      ((IW'(len_reg) == cand_reg) || (len_reg == second_cnt_reg));
            start_x = l1_x - cand_reg;
        end else begin
            accept  = (mode_reg == MODE_CONTAINED) && (len_reg == first_cnt_reg);
            start_x = cand_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        cand_next       = cand_reg;
        k_next          = k_reg;
        span_next       = span_reg;
        len_next        = len_reg;
        pen_next        = pen_reg;
        pl_next         = pl_reg;
        kmp_next        = kmp_reg;
        lim_next        = lim_reg;
        lim3_next       = lim3_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        hits_next       = hits_reg;
        cap_next        = cap_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        we_first        = 1'b0;
        we_second       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_op)
                        OP_LOAD_FIRST: begin
                            if (first_cnt_reg < FULL) begin
                                we_first       = 1'b1;
                                first_cnt_next = first_cnt_reg + 1'b1;
                            end
                        end
                        OP_LOAD_SECOND: begin
                            if (second_cnt_reg < FULL) begin
                                we_second       = 1'b1;
                                second_cnt_next = second_cnt_reg + 1'b1;
                            end
                        end
                        OP_START: begin
                            if (max_hits_reg == '0) begin
                                cap_next = HITS_W'(1);
                            end else if (max_hits_reg > HIT_CAP) begin
                                cap_next = HIT_CAP;
                            end else begin
                                cap_next = max_hits_reg;
                            end
                            if (mode_reg == MODE_CONTAINED) begin
                                cand_next = IW'(1);
                                lim_next  = LW'(first_cnt_reg);
                                lim3_next = (LW + 2)'(first_cnt_reg) +
                                            ((LW + 2)'(first_cnt_reg) << 1);
                            end else begin
                                cand_next = IW'(min_ovl_reg);
                                lim_next  = LW'(min_ovl_reg);
                                lim3_next = (LW + 2)'(min_ovl_reg) +
                                            ((LW + 2)'(min_ovl_reg) << 1);
                            end
                            hits_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_CAND;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CAND: begin
                if (!cand_ok) begin
                    state_next = S_FLUSH;
                end else begin
                    k_next    = '0;
                    pen_next  = '0;
                    pl_next   = '0;
                    kmp_next  = '0;
                    span_next = span_c;
                    case (mode_reg)
                        MODE_FORWARD: begin
                            a_next = AW'(l1_x - cand_reg);
                            b_next = '0;
                        end
                        MODE_REVERSE: begin
                            a_next = AW'(cand_reg - 1'b1);
                            b_next = AW'(second_cnt_reg - 1'b1);
                        end
                        default: begin
                            a_next = '0;
                            b_next = AW'(cand_reg);
                        end
                    endcase
                    if (span_c == '0) begin
                        len_next   = '0;
                        state_next = S_JUDGE;
                    end else begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (stop) begin
                    len_next   = k_reg;
                    state_next = S_JUDGE;
                end else if (k_reg + 1'b1 == span_reg) begin
                    len_next   = span_reg;
                    state_next = S_JUDGE;
                end else begin
                    k_next   = k_reg + 1'b1;
                    kmp_next = kmp_reg + KW'(max_pen_reg);
                    if (mismatch) begin
                        pen_next = pen_upd;
                        pl_next  = pl_upd;
                    end
                    if (mode_reg == MODE_REVERSE) begin
                        a_next = a_reg - 1'b1;
                        b_next = b_reg - 1'b1;
                    end else begin
                        a_next = a_reg + 1'b1;
                        b_next = b_reg + 1'b1;
                    end
                    state_next = S_ADDR;
                end
            end
            S_JUDGE: begin
                if (!(accept && pend_valid_reg && !out_free)) begin
                    if (accept) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_found_next = 1'b1;
                            out_start_next = pend_start_reg;
                            out_len_next   = pend_len_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = start_x[OUT_W-1:0];
                        pend_len_next   = OUT_W'(len_reg);
                        hits_next       = hits_reg + 1'b1;
                    end
                    cand_next  = cand_reg + 1'b1;
                    state_next = S_CAND;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_found_next  = pend_valid_reg;
                    out_start_next  = pend_valid_reg ? pend_start_reg : '0;
                    out_len_next    = pend_valid_reg ? pend_len_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= RST_SEARCH_MODE;
            max_pen_reg  <= RST_MAX_PENALTY;
            min_ovl_reg  <= RST_MIN_OVERLAP;
            max_hits_reg <= RST_MAX_HITS;
            use_q2_reg   <= RST_USE_QUAL2;
            q_thr_reg    <= RST_QUAL_THR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_SEARCH_MODE: mode_reg     <= cfg_data[1:0];
                REG_MAX_PENALTY: max_pen_reg  <= cfg_data[MPEN_W-1:0];
                REG_MIN_OVERLAP: min_ovl_reg  <= cfg_data[MIN_W-1:0];
                REG_MAX_HITS:    max_hits_reg <= cfg_data[HITS_W-1:0];
                REG_USE_QUAL2:   use_q2_reg   <= cfg_data[0];
                REG_QUAL_THR:    q_thr_reg    <= cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            hits_reg       <= '0;
            cap_reg        <= HITS_W'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            hits_reg       <= hits_next;
            cap_reg        <= cap_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg       <= cand_next;
        k_reg          <= k_next;
        span_reg       <= span_next;
        len_reg        <= len_next;
        pen_reg        <= pen_next;
        pl_reg         <= pl_next;
        kmp_reg        <= kmp_next;
        lim_reg        <= lim_next;
        lim3_reg       <= lim3_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        out_found_reg  <= out_found_next;
        out_start_reg  <= out_start_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    qwos_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_LEN)
    ) u_first_ram (
        .aclk (aclk),
        .we   (we_first),
        .waddr(first_cnt_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(a_reg),
        .rdata(rd_first)
    );

    qwos_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_LEN)
    ) u_second_ram (
        .aclk (aclk),
        .we   (we_second),
        .waddr(second_cnt_reg[AW-1:0]),
        .wdata(wdata),
        .raddr(b_reg),
        .rdata(rd_second)
    );

    a_hits_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        hits_reg <= cap_reg)
        else $error("hit count beyond limit");

    a_counts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && out_free) |=> (first_cnt_reg == '0 && second_cnt_reg == '0))
        else $error("store counts not cleared after search");

    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("not-found result without last");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending hit left over while idle");

    a_scan_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (k_reg < span_reg))
        else $error("scan position beyond candidate length");

endmodule
